@@ sv/ltc_pkg.sv @@
// ============================================================================
// ltc_pkg
// Shared constants, codes and control structs of the line table cursor tracker
// ============================================================================
`default_nettype none

package ltc_pkg;

    localparam int MAX_LINES_DEF = 1024;
    localparam int LEN_BITS_DEF  = 16;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;

    // operation selector codes
    localparam logic [2:0] FN_INSERT    = 3'd0;
    localparam logic [2:0] FN_BACKSPACE = 3'd1;
    localparam logic [2:0] FN_DELETE    = 3'd2;
    localparam logic [2:0] FN_SET       = 3'd3;
    localparam logic [2:0] FN_MOVE_H    = 3'd4;
    localparam logic [2:0] FN_MOVE_V    = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_NODEL = 2'd3;

    typedef enum logic [2:0] {
        RD_ROW, RD_B, RD_ZERO, RD_LAST, RD_DROP0, RD_INC, RD_DEC
    } rd_sel_t;

    typedef enum logic [2:0] {
        WR_NONE, WR_PRIM, WR_UP, WR_DOWN, WR_CLR, WR_RIGHT
    } wr_sel_t;

    typedef enum logic [2:0] {
        K_NONE, K_WRITE, K_NL, K_JOIN, K_PLACE
    } kind_t;

    typedef enum logic [1:0] {
        PM_KEEP, PM_INC, PM_DEC, PM_ACC
    } pos_mode_t;

    typedef enum logic [1:0] {
        LM_KEEP, LM_INC, LM_DEC
    } last_mode_t;

    typedef struct packed {
        logic    load;
        rd_sel_t rd_sel;
        logic    cap_a;
        logic    eval;
        wr_sel_t wr_sel;
        logic    acc_add;
        logic    commit;
    } cmd_t;

    typedef struct packed {
        kind_t eval_kind;
        logic  eval_nr_zero;
        logic  up_move;
        logic  up_end;
        logic  drop_move;
        logic  down_end;
        logic  sum_end;
    } stat_t;

endpackage

`default_nettype wire

@@ sv/ltc_in_if.sv @@
// ============================================================================
// ltc_in_if
// Request channel: one edit or cursor operation per transaction
// ============================================================================
`default_nettype none

interface ltc_in_if;
    logic              valid;
    logic              ready;
    logic [2:0]        func;
    logic [7:0]        char_code;
    logic [9:0]        target_row;
    logic [15:0]       target_col;
    logic signed [1:0] step;

    modport source (output valid, func, char_code, target_row, target_col, step,
                    input ready);
    modport sink   (input valid, func, char_code, target_row, target_col, step,
                    output ready);
endinterface

`default_nettype wire

@@ sv/ltc_out_if.sv @@
// ============================================================================
// ltc_out_if
// Response channel: cursor and table summary after each operation
// ============================================================================
`default_nettype none

interface ltc_out_if;
    logic        valid;
    logic        ready;
    logic [9:0]  cursor_row;
    logic [15:0] cursor_col;
    logic [9:0]  last_line;
    logic [23:0] text_pos;
    logic [1:0]  status;

    modport source (output valid, cursor_row, cursor_col, last_line, text_pos, status,
                    input ready);
    modport sink   (input valid, cursor_row, cursor_col, last_line, text_pos, status,
                    output ready);
endinterface

`default_nettype wire

@@ sv/ltc_ctrl.sv @@
// ============================================================================
// ltc_ctrl
// Sequencer: reads operands, branches on the plan, walks the table loops
// ============================================================================
`default_nettype none

module ltc_ctrl
    import ltc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_ready,
    output logic  rsp_valid,
    input  logic  rsp_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_RDB  = 10'b0000000010,
        S_EVAL = 10'b0000000100,
        S_WR   = 10'b0000001000,
        S_UP   = 10'b0000010000,
        S_NLW  = 10'b0000100000,
        S_DOWN = 10'b0001000000,
        S_CLR  = 10'b0010000000,
        S_SUM  = 10'b0100000000,
        S_DONE = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    kind_t  kind_reg, kind_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd            = '{load: 1'b0, rd_sel: RD_ROW, cap_a: 1'b0, eval: 1'b0,
                           wr_sel: WR_NONE, acc_add: 1'b0, commit: 1'b0};
        state_next     = state_reg;
        kind_next      = kind_reg;
        req_ready      = 1'b0;
        out_valid_next = out_valid_reg && !rsp_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RDB;
                end
            end
            S_RDB:
            begin
                cmd.cap_a  = 1'b1;
                cmd.rd_sel = RD_B;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                cmd.rd_sel = RD_ZERO;
                kind_next  = stat.eval_kind;
                if (stat.eval_kind == K_WRITE || stat.eval_kind == K_NL ||
                    stat.eval_kind == K_JOIN)
                    state_next = S_WR;
                else if (stat.eval_kind == K_PLACE && !stat.eval_nr_zero)
                    state_next = S_SUM;
                else
                    state_next = S_DONE;
            end
            S_WR:
            begin
                cmd.wr_sel = WR_PRIM;
                if (kind_reg == K_NL)
                begin
                    if (stat.up_move)
                    begin
                        cmd.rd_sel = RD_LAST;
                        state_next = S_UP;
                    end
                    else
                        state_next = S_NLW;
                end
                else if (kind_reg == K_JOIN)
                begin
                    if (stat.drop_move)
                    begin
                        cmd.rd_sel = RD_DROP0;
                        state_next = S_DOWN;
                    end
                    else
                        state_next = S_CLR;
                end
                else
                    state_next = S_DONE;
            end
            S_UP:
            begin
                cmd.wr_sel = WR_UP;
                if (stat.up_end)
                    state_next = S_NLW;
                else
                    cmd.rd_sel = RD_DEC;
            end
            S_NLW:
            begin
                cmd.wr_sel = WR_RIGHT;
                state_next = S_DONE;
            end
            S_DOWN:
            begin
                cmd.wr_sel = WR_DOWN;
                if (stat.down_end)
                    state_next = S_CLR;
                else
                    cmd.rd_sel = RD_INC;
            end
            S_CLR:
            begin
                cmd.wr_sel = WR_CLR;
                state_next = S_DONE;
            end
            S_SUM:
            begin
                cmd.acc_add = 1'b1;
                if (stat.sum_end)
                    state_next = S_DONE;
                else
                    cmd.rd_sel = RD_INC;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kind_reg      <= K_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ sv/ltc_datapath.sv @@
// ============================================================================
// ltc_datapath
// Line length memory, cursor registers, operation planning and prefix sum
// ============================================================================
`default_nettype none

module ltc_datapath
    import ltc_pkg::*;
#(
    parameter int MAX_LINES = MAX_LINES_DEF,
    parameter int LEN_BITS  = LEN_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output stat_t             stat,
    input  logic [2:0]        func,
    input  logic [7:0]        char_code,
    input  logic [9:0]        target_row,
    input  logic [15:0]       target_col,
    input  logic signed [1:0] step,
    output logic [9:0]        cursor_row,
    output logic [15:0]       cursor_col,
    output logic [9:0]        last_line,
    output logic [23:0]       text_pos,
    output logic [1:0]        status
);

    localparam int RW = $clog2(MAX_LINES);
    localparam int TW = (RW > 10) ? RW : 10;
    localparam int AW = TW + 2;
    localparam int LW = LEN_BITS;
    localparam int CW = (LW > 16) ? LW : 16;
    localparam int CS = LW + 3;
    localparam int PW = 24;
    localparam logic [LW-1:0]        LEN_MAX  = {LW{1'b1}};
    localparam logic signed [AW-1:0] ML_S     = AW'(MAX_LINES);
    localparam logic [RW-1:0]        LAST_MAX = RW'(MAX_LINES - 1);

    // line length memory, no reset: the fill count masks unwritten entries
    logic [LW-1:0] len_mem [MAX_LINES];

    logic [2:0]        func_reg;
    logic [7:0]        char_reg;
    logic [9:0]        trow_reg;
    logic [15:0]       tcol_reg;
    logic signed [1:0] step_reg;

    logic [LW-1:0] a_reg, rdata_reg, rdata;
    logic          zero_reg, zero_next;
    logic [RW-1:0] idx_reg;

    logic [RW-1:0] row_reg, last_reg;
    logic [LW-1:0] col_reg;
    logic [PW-1:0] pos_reg, acc_reg;
    logic [RW:0]   hw_reg;

    logic [1:0]    st_reg, st_next;
    logic [RW-1:0] prim_addr_reg, prim_addr_next;
    logic [LW-1:0] prim_val_reg, prim_val_next;
    logic [LW-1:0] aux_reg, aux_next;
    logic [RW-1:0] nr_reg, nr_next;
    logic [LW-1:0] nc_reg, nc_next;
    pos_mode_t     pm_reg, pm_next;
    last_mode_t    lm_reg, lm_next;
    kind_t         kind_next;

    logic [9:0]    o_row_reg, o_last_reg;
    logic [15:0]   o_col_reg;
    logic [PW-1:0] o_pos_reg;
    logic [1:0]    o_st_reg;

    logic signed [AW-1:0] step_a, row_s, rv_s, b_full, ra_full;
    logic signed [CS-1:0] step_c;
    logic [RW-1:0]        ra, wa;
    logic [LW-1:0]        wd;
    logic                 we;
    logic [RW-1:0]        last_cm;
    logic [PW-1:0]        pos_cm;

    assign rdata  = zero_reg ? '0 : rdata_reg;
    assign step_a = {{(AW-2){step_reg[1]}}, step_reg};
    assign step_c = {{(CS-2){step_reg[1]}}, step_reg};
    assign row_s  = AW'(row_reg);
    assign rv_s   = row_s + step_a;

    // second operand address per operation
    always_comb
    begin
        unique case (func_reg)
            FN_BACKSPACE, FN_MOVE_H: b_full = row_s - AW'(1);
            FN_DELETE:               b_full = row_s + AW'(1);
            FN_SET:                  b_full = AW'(trow_reg);
            FN_MOVE_V:               b_full = rv_s;
            default:                 b_full = row_s;
        endcase
    end

    // read port address
    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_ROW:   ra_full = row_s;
            RD_B:     ra_full = b_full;
            RD_ZERO:  ra_full = '0;
            RD_LAST:  ra_full = AW'(last_reg);
            RD_DROP0: ra_full = AW'(prim_addr_reg) + AW'(2);
            RD_INC:   ra_full = AW'(idx_reg) + AW'(1);
            RD_DEC:   ra_full = AW'(idx_reg) - AW'(1);
            default:  ra_full = '0;
        endcase
        ra        = ra_full[RW-1:0];
        zero_next = (ra_full < 0) || (ra_full >= ML_S) ||
                    (ra_full >= $signed(AW'(hw_reg)));
    end

    // write port
    always_comb
    begin
        we = 1'b1;
        wa = prim_addr_reg;
        wd = prim_val_reg;
        unique case (cmd.wr_sel)
            WR_PRIM:
            begin
                wa = prim_addr_reg;
                wd = prim_val_reg;
            end
            WR_UP:
            begin
                wa = idx_reg + RW'(1);
                wd = rdata;
            end
            WR_DOWN:
            begin
                wa = idx_reg - RW'(1);
                wd = rdata;
            end
            WR_CLR:
            begin
                wa = last_reg;
                wd = '0;
            end
            WR_RIGHT:
            begin
                wa = prim_addr_reg + RW'(1);
                wd = aux_reg;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            len_mem[wa] <= wd;
        rdata_reg <= len_mem[ra];
    end

    // operation planning from the two operands
    always_comb
    begin
        logic [LW:0]          sum_ab;
        logic [LW-1:0]        right;
        logic signed [CS-1:0] col_s, c2;
        sum_ab = {1'b0, a_reg} + {1'b0, rdata};
        right  = (a_reg >= col_reg) ? (a_reg - col_reg) : '0;
        col_s  = $signed(CS'(col_reg)) + step_c;
        c2     = col_s + $signed(CS'(rdata)) + CS'(1);

        kind_next      = K_NONE;
        st_next        = ST_OK;
        prim_addr_next = row_reg;
        prim_val_next  = a_reg;
        aux_next       = right;
        nr_next        = row_reg;
        nc_next        = col_reg;
        pm_next        = PM_KEEP;
        lm_next        = LM_KEEP;
        unique case (func_reg)
            FN_INSERT:
            begin
                if (char_reg == NEWLINE_CODE)
                begin
                    if (last_reg == LAST_MAX)
                        st_next = ST_FULL;
                    else
                    begin
                        kind_next     = K_NL;
                        prim_val_next = a_reg - right;
                        nr_next       = row_reg + RW'(1);
                        nc_next       = '0;
                        lm_next       = LM_INC;
                        pm_next       = PM_INC;
                    end
                end
                else if (a_reg == LEN_MAX)
                    st_next = ST_FULL;
                else
                begin
                    kind_next     = K_WRITE;
                    prim_val_next = a_reg + LW'(1);
                    nc_next       = col_reg + LW'(1);
                    pm_next       = PM_INC;
                end
            end
            FN_BACKSPACE:
            begin
                if (col_reg != '0)
                begin
                    kind_next     = K_WRITE;
                    prim_val_next = a_reg - LW'(1);
                    nc_next       = col_reg - LW'(1);
                    pm_next       = PM_DEC;
                end
                else if (row_reg != '0)
                begin
                    if (sum_ab[LW])
                        st_next = ST_FULL;
                    else
                    begin
                        kind_next      = K_JOIN;
                        prim_addr_next = row_reg - RW'(1);
                        prim_val_next  = sum_ab[LW-1:0];
                        nr_next        = row_reg - RW'(1);
                        nc_next        = rdata;
                        lm_next        = LM_DEC;
                        pm_next        = PM_DEC;
                    end
                end
                else
                    st_next = ST_NODEL;
            end
            FN_DELETE:
            begin
                if (col_reg < a_reg)
                begin
                    kind_next     = K_WRITE;
                    prim_val_next = a_reg - LW'(1);
                end
                else if (row_reg < last_reg)
                begin
                    if (sum_ab[LW])
                        st_next = ST_FULL;
                    else
                    begin
                        kind_next     = K_JOIN;
                        prim_val_next = sum_ab[LW-1:0];
                        lm_next       = LM_DEC;
                    end
                end
                else
                    st_next = ST_NODEL;
            end
            FN_SET:
            begin
                if (TW'(trow_reg) > TW'(last_reg) || CW'(tcol_reg) > CW'(rdata))
                    st_next = ST_RANGE;
                else
                begin
                    kind_next = K_PLACE;
                    nr_next   = RW'(trow_reg);
                    nc_next   = LW'(tcol_reg);
                    pm_next   = PM_ACC;
                end
            end
            FN_MOVE_H:
            begin
                if (col_s > $signed(CS'(a_reg)))
                begin
                    if (row_reg == last_reg)
                        st_next = ST_RANGE;
                    else
                    begin
                        kind_next = K_PLACE;
                        nr_next   = row_reg + RW'(1);
                        nc_next   = '0;
                        pm_next   = PM_ACC;
                    end
                end
                else if (col_s < 0)
                begin
                    if (row_reg == '0 || c2 < 0)
                        st_next = ST_RANGE;
                    else
                    begin
                        kind_next = K_PLACE;
                        nr_next   = row_reg - RW'(1);
                        nc_next   = LW'(c2);
                        pm_next   = PM_ACC;
                    end
                end
                else
                begin
                    kind_next = K_PLACE;
                    nc_next   = LW'(col_s);
                    pm_next   = PM_ACC;
                end
            end
            FN_MOVE_V:
            begin
                if (rv_s < 0 || rv_s > $signed(AW'(last_reg)))
                    st_next = ST_RANGE;
                else
                begin
                    kind_next = K_PLACE;
                    nr_next   = RW'(rv_s);
                    nc_next   = (col_reg > rdata) ? rdata : col_reg;
                    pm_next   = PM_ACC;
                end
            end
            default:
            begin
                kind_next = K_NONE;
            end
        endcase
    end

    // values that the commit step takes over
    always_comb
    begin
        unique case (lm_reg)
            LM_INC:  last_cm = last_reg + RW'(1);
            LM_DEC:  last_cm = last_reg - RW'(1);
            default: last_cm = last_reg;
        endcase
        unique case (pm_reg)
            PM_INC:  pos_cm = pos_reg + PW'(1);
            PM_DEC:  pos_cm = pos_reg - PW'(1);
            PM_ACC:  pos_cm = acc_reg;
            default: pos_cm = pos_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            last_reg <= '0;
            pos_reg  <= '0;
            hw_reg   <= '0;
        end
        else
        begin
            if (we && {1'b0, wa} >= hw_reg)
                hw_reg <= {1'b0, wa} + (RW+1)'(1);
            if (cmd.commit)
            begin
                row_reg  <= nr_reg;
                col_reg  <= nc_reg;
                last_reg <= last_cm;
                pos_reg  <= pos_cm;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        zero_reg <= zero_next;
        idx_reg  <= ra;
        if (cmd.load)
        begin
            func_reg <= func;
            char_reg <= char_code;
            trow_reg <= target_row;
            tcol_reg <= target_col;
            step_reg <= step;
        end
        if (cmd.cap_a)
            a_reg <= rdata;
        if (cmd.eval)
        begin
            st_reg        <= st_next;
            prim_addr_reg <= prim_addr_next;
            prim_val_reg  <= prim_val_next;
            aux_reg       <= aux_next;
            nr_reg        <= nr_next;
            nc_reg        <= nc_next;
            pm_reg        <= pm_next;
            lm_reg        <= lm_next;
            acc_reg       <= PW'(nc_next);
        end
        else if (cmd.acc_add)
            acc_reg <= acc_reg + PW'(rdata) + PW'(1);
        if (cmd.commit)
        begin
            o_row_reg  <= 10'(nr_reg);
            o_col_reg  <= 16'(nc_reg);
            o_last_reg <= 10'(last_cm);
            o_pos_reg  <= pos_cm;
            o_st_reg   <= st_reg;
        end
    end

    assign stat.eval_kind    = kind_next;
    assign stat.eval_nr_zero = (nr_next == '0);
    assign stat.up_move      = (last_reg > row_reg);
    assign stat.up_end       = (idx_reg == row_reg + RW'(1));
    assign stat.drop_move    = (({1'b0, prim_addr_reg} + (RW+1)'(1)) < {1'b0, last_reg});
    assign stat.down_end     = (idx_reg == last_reg);
    assign stat.sum_end      = (idx_reg == nr_reg - RW'(1));

    assign cursor_row = o_row_reg;
    assign cursor_col = o_col_reg;
    assign last_line  = o_last_reg;
    assign text_pos   = o_pos_reg;
    assign status     = o_st_reg;

endmodule

`default_nettype wire

@@ sv/line_table_cursor_tracker.sv @@
// ============================================================================
// line_table_cursor_tracker
// Line length table with cursor row, column and linear offset tracking
// ============================================================================
// sequence: the operands are read, the operation is planned, then the table is written;
//   a failed operation writes nothing, set-cursor and moves sum the rows above the target
//   (one table read per row), a newline shifts the lines below down and a join shifts them up
// one transaction at a time; the walks go through the single read port of the
//   line length memory
// reset: cursor, last line and offset clear at once; the table needs no
//   clearing pass, a fill count makes entries never written read as zero
`default_nettype none

module line_table_cursor_tracker
    import ltc_pkg::*;
#(
    parameter int MAX_LINES = MAX_LINES_DEF,
    parameter int LEN_BITS  = LEN_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    ltc_in_if.sink    req,
    ltc_out_if.source rsp
);

    // command and status between sequencer and datapath
    cmd_t  cmd;
    stat_t stat;

    // the sequencer takes a transaction only in its idle state; the result
    // register lets the next transaction in while a response is still pending
    ltc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath holds the memory, the cursor state and the output register
    ltc_datapath #(
        .MAX_LINES (MAX_LINES),
        .LEN_BITS  (LEN_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .func       (req.func),
        .char_code  (req.char_code),
        .target_row (req.target_row),
        .target_col (req.target_col),
        .step       (req.step),
        .cursor_row (rsp.cursor_row),
        .cursor_col (rsp.cursor_col),
        .last_line  (rsp.last_line),
        .text_pos   (rsp.text_pos),
        .status     (rsp.status)
    );

    // a taken request keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request taken while previous operation in flight");

    // a new response only comes out of a busy cycle
    a_rsp_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(!req.ready))
        else $error("response raised without an operation in flight");

    // the sequencer never signals a result while it is ready for more work
    a_no_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> !cmd.commit)
        else $error("commit issued from idle");

endmodule

`default_nettype wire
